// ===== design/lovt_pkg.sv =====
// Shared constants for the level-order value table.
// No dependencies; the top level references these by scoped names.
package lovt_pkg;

    // Operation codes carried in the input item
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;
    localparam logic [1:0] STAT_MISSING = 2'd3;

    // Fixed field widths of the stream payloads
    localparam int OPCODE_W   = 2;
    localparam int IN_VALUE_W = 32;
    localparam int COUNT_W    = 7;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 16;

endpackage

// ===== design/level_order_value_table.sv =====
// Level-order value table: complete binary tree of keys held in one RAM plus a count.
// Depends on lovt_pkg (codes, field widths) and lovt_ram (entry storage).
//
//  channel | direction | tdata fields (low bit up)                   | tuser
//  s_*     | in        | opcode[1:0], value[33:2], zero pad          | -
//  m_*     | out       | found[0], status[2:1], entry_count[9:3], pad | -
//
// Insert, an unused opcode and any operation on an empty table go straight from accept
// to the finish state; delete and search first scan the live entries one RAM read per
// cycle, since the entry RAM has a single read port. Reset clears the count and all
// control state; the entry RAM is not cleared, since only entries below the count ever
// reach a result. A finished result waits in the output register while the next item
// is accepted and worked on; that item holds in its final state only until the output
// register frees.
module level_order_value_table #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lovt_pkg::S_TDATA_W-1:0]    s_tdata,   // opcode, value, zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lovt_pkg::M_TDATA_W-1:0]    m_tdata    // found, status, entry_count, pad
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // Registers
    state_t                 state_reg,      state_next;
    logic [1:0]             op_reg,         op_next;
    logic [VALUE_WIDTH-1:0] key_reg,        key_next;
    logic [AW-1:0]          idx_reg,        idx_next;
    logic [AW-1:0]          hit_idx_reg,    hit_idx_next;
    logic                   hit_valid_reg,  hit_valid_next;
    logic                   res_found_reg,  res_found_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic [CW-1:0]          count_reg,      count_next;
    logic                   m_tvalid_reg,   m_tvalid_next;
    logic                   m_found_reg,    m_found_next;
    logic [1:0]             m_status_reg,   m_status_next;
    logic [lovt_pkg::COUNT_W-1:0] m_count_reg, m_count_next;

    // Input unpacking
    logic [1:0]                          in_op;
    logic [lovt_pkg::IN_VALUE_W-1:0]     in_value;
    logic [lovt_pkg::IN_VALUE_W+VALUE_WIDTH-1:0] in_value_ext;
    logic [VALUE_WIDTH-1:0]              in_key;

    // RAM ports
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;

    // Scan helpers
    logic                   hit_now;
    logic                   hit_any;
    logic [AW-1:0]          hit_final;
    logic [CW-1:0]          count_m1;
    logic                   scan_last;
    logic                   accept;
    logic [CW+lovt_pkg::COUNT_W-1:0] count_wide;

    assign in_op        = s_tdata[lovt_pkg::OPCODE_W-1:0];
    assign in_value     = s_tdata[lovt_pkg::OPCODE_W+lovt_pkg::IN_VALUE_W-1:lovt_pkg::OPCODE_W];
    // sign-extend the 32-bit field, then keep VALUE_WIDTH bits
    assign in_value_ext = {{VALUE_WIDTH{in_value[lovt_pkg::IN_VALUE_W-1]}}, in_value};
    assign in_key       = in_value_ext[VALUE_WIDTH-1:0];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Read data during a scan belongs to entry idx_reg
    assign hit_now   = (rd_data == key_reg);
    assign hit_any   = hit_now || hit_valid_reg;
    assign hit_final = hit_now ? idx_reg : hit_idx_reg;
    assign count_m1  = CW'(count_reg - 1'b1);
    assign scan_last = (CW'(idx_reg) == count_m1);
    assign count_wide = (CW + lovt_pkg::COUNT_W)'(count_reg);

    lovt_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_valid_next  = hit_valid_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        count_next      = count_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_found_next    = m_found_reg;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;

        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = in_key;
        rd_addr = '0;

        // drop the held result once it is taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // issue the read of entry 0 so a scan can compare next cycle
                rd_addr = '0;
                if (accept)
                begin
                    op_next         = in_op;
                    key_next        = in_key;
                    idx_next        = '0;
                    hit_valid_next  = 1'b0;
                    res_found_next  = 1'b0;
                    res_status_next = lovt_pkg::STAT_OK;
                    state_next      = S_FINISH;
                    case (in_op)
                        lovt_pkg::OP_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                res_status_next = lovt_pkg::STAT_FULL;
                            end
                            else
                            begin
                                // append at the next level-order slot
                                wr_en      = 1'b1;
                                count_next = CW'(count_reg + 1'b1);
                            end
                        end
                        lovt_pkg::OP_DELETE,
                        lovt_pkg::OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = lovt_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // unused opcode: the table is left unchanged
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                rd_addr = AW'(idx_reg + 1'b1);
                if (hit_now)
                begin
                    hit_idx_next   = idx_reg;
                    hit_valid_next = 1'b1;
                end
                if (scan_last)
                begin
                    state_next = S_FINISH;
                    if (!hit_any)
                    begin
                        res_status_next = lovt_pkg::STAT_MISSING;
                    end
                    else
                    begin
                        res_found_next = 1'b1;
                        if (op_reg == lovt_pkg::OP_DELETE)
                        begin
                            // rd_data is the last live entry: move it onto the match
                            wr_en      = 1'b1;
                            wr_addr    = hit_final;
                            wr_data    = rd_data;
                            count_next = count_m1;
                        end
                    end
                end
                else
                begin
                    idx_next = AW'(idx_reg + 1'b1);
                end
            end

            S_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = res_found_reg;
                    m_status_next = res_status_reg;
                    m_count_next  = count_wide[lovt_pkg::COUNT_W-1:0];
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            hit_valid_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            hit_valid_reg  <= hit_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        hit_idx_reg    <= hit_idx_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        m_found_reg    <= m_found_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_count_reg, m_status_reg, m_found_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CW'(idx_reg) < count_reg))
        else $error("scan index beyond live entries");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_found_reg) |-> (m_status_reg == lovt_pkg::STAT_OK))
        else $error("found result without ok status");

    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && scan_last && hit_any && (op_reg == lovt_pkg::OP_DELETE))
        |=> (count_reg == CW'($past(count_reg) - 1'b1)))
        else $error("matched delete did not shrink the count");
`endif

endmodule

// ===== design/lovt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lovt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== tb/sv/level_order_value_table_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for level_order_value_table: a shadow table predicts each result.
// Depends on lovt_pkg for opcodes, status codes and stream widths, and on level_order_value_table.
module level_order_value_table_test;

    localparam int         SLOTS         = 64;
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES = 80;
    localparam int         MAX_REPORTS   = 10;

    typedef struct packed {
        logic       found;
        logic [1:0] status;
        logic [6:0] entry_count;
    } lookup_result_t;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BLEND} traffic_mix_t;

    // Shadow copy of the table: predicts every result and holds it until it arrives
    class lovt_scoreboard;
        logic [lovt_pkg::IN_VALUE_W-1:0] keys [SLOTS];
        int                    live;
        lookup_result_t        awaited[$];
        int                    mismatches;

        function new();
            live       = 0;
            mismatches = 0;
        endfunction

        // Apply one accepted item to the shadow table and queue its result
        function void note_input(logic [1:0] op, logic [lovt_pkg::IN_VALUE_W-1:0] key);
            lookup_result_t r;
            int             hit;
            r        = '0;
            r.status = lovt_pkg::STAT_OK;
            if (op == lovt_pkg::OP_INSERT)
            begin
                if (live >= SLOTS)
                    r.status = lovt_pkg::STAT_FULL;
                else
                begin
                    keys[live] = key;
                    live++;
                end
            end
            else if (op == lovt_pkg::OP_DELETE || op == lovt_pkg::OP_SEARCH)
            begin
                if (live == 0)
                    r.status = lovt_pkg::STAT_EMPTY;
                else
                begin
                    // last match in level order wins
                    hit = -1;
                    for (int k = 0; k < live; k++)
                        if (keys[k] == key)
                            hit = k;
                    if (hit < 0)
                        r.status = lovt_pkg::STAT_MISSING;
                    else
                    begin
                        r.found = 1'b1;
                        if (op == lovt_pkg::OP_DELETE)
                        begin
                            // move the last entry into the hole; a lone root just empties
                            live--;
                            keys[hit] = keys[live];
                        end
                    end
                end
            end
            r.entry_count = 7'(live);
            awaited.push_back(r);
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(logic [lovt_pkg::M_TDATA_W-1:0] tdata);
            lookup_result_t got;
            lookup_result_t want;
            got.found       = tdata[0];
            got.status      = tdata[2:1];
            got.entry_count = tdata[9:3];
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: found=%0d status=%0d count=%0d",
                             got.found, got.status, got.entry_count);
                return;
            end
            want = awaited.pop_front();
            if (got.found !== want.found || got.status !== want.status ||
                got.entry_count !== want.entry_count)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"result mismatch: expected found=%0d status=%0d count=%0d,",
                              " got found=%0d status=%0d count=%0d"},
                             want.found, want.status, want.entry_count,
                             got.found, got.status, got.entry_count);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function logic [lovt_pkg::IN_VALUE_W-1:0] any_live_key();
            if (live == 0)
                return $urandom;
            return keys[$urandom_range(live - 1)];
        endfunction
    endclass

    logic                             clk      = 1'b0;
    logic                             rst_n    = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [lovt_pkg::S_TDATA_W-1:0]   s_tdata  = '0;      // opcode, value, zero pad
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [lovt_pkg::M_TDATA_W-1:0]   m_tdata;            // found, status, entry_count, pad

    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    lovt_scoreboard table_sb;

    always #4 clk = ~clk;

    level_order_value_table u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Offer one item, idling first at the current rate; note it once accepted
    task automatic send_item(input logic [1:0] op,
                             input logic [lovt_pkg::IN_VALUE_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(lovt_pkg::S_TDATA_W - lovt_pkg::IN_VALUE_W - lovt_pkg::OPCODE_W){1'b0}},
                     key, op};
        do
            @(posedge clk);
        while (!s_tready);
        table_sb.note_input(op, key);
    endtask

    // Favor live keys and a small pool so deletes and searches hit and duplicates pile up
    function automatic logic [lovt_pkg::IN_VALUE_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40 && table_sb.live > 0)
            return table_sb.any_live_key();
        if (roll < 70)
            return lovt_pkg::IN_VALUE_W'(int'($urandom_range(8)) - 4);
        if (roll < 90)
            return $urandom;
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [1:0] pick_op(traffic_mix_t mix);
        int roll;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL:
                return roll < 75 ? lovt_pkg::OP_INSERT : roll < 90 ? lovt_pkg::OP_SEARCH :
                       roll < 98 ? lovt_pkg::OP_DELETE : OP_UNUSED;
            MIX_DRAIN:
                return roll < 70 ? lovt_pkg::OP_DELETE : roll < 85 ? lovt_pkg::OP_SEARCH :
                       roll < 98 ? lovt_pkg::OP_INSERT : OP_UNUSED;
            default:
                return roll < 35 ? lovt_pkg::OP_INSERT : roll < 65 ? lovt_pkg::OP_DELETE :
                       roll < 95 ? lovt_pkg::OP_SEARCH : OP_UNUSED;
        endcase
    endfunction

    // Run bursts of one traffic mix each; open with a long fill so the table hits full
    task automatic run_traffic(input int n_items);
        int           sent;
        int           burst;
        traffic_mix_t mix;
        sent = 0;
        while (sent < n_items)
        begin
            if (sent == 0)
            begin
                mix   = MIX_FILL;
                burst = 120;
            end
            else
            begin
                mix   = traffic_mix_t'($urandom_range(2));
                burst = (mix == MIX_FILL) ? $urandom_range(120, 40) : $urandom_range(60, 10);
            end
            for (int k = 0; k < burst && sent < n_items; k++)
            begin
                send_item(pick_op(mix), pick_key());
                sent++;
            end
        end
    endtask

    // Result side: check each accepted result, stall at random, and twice hold off
    // for a long stretch so the block backs up and stalls its input
    initial
    begin
        int hold_left;
        int seen;
        hold_left = 0;
        seen      = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                table_sb.check_result(m_tdata);
                seen++;
                if (seen == 300 || seen == 1000)
                    hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        table_sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 63;

        // empty table, unused opcode, lone root delete
        send_item(lovt_pkg::OP_SEARCH, 32'h0000_0000);
        send_item(lovt_pkg::OP_DELETE, 32'hFFFF_FFFF);
        send_item(OP_UNUSED, 32'h5555_AAAA);
        send_item(lovt_pkg::OP_INSERT, 32'h7FFF_FFFF);
        send_item(lovt_pkg::OP_DELETE, 32'h7FFF_FFFF);
        send_item(lovt_pkg::OP_SEARCH, 32'h7FFF_FFFF);
        // extremes and a duplicate key
        send_item(lovt_pkg::OP_INSERT, 32'h8000_0000);
        send_item(lovt_pkg::OP_INSERT, 32'hFFFF_FFFF);
        send_item(lovt_pkg::OP_INSERT, 32'h8000_0000);
        send_item(lovt_pkg::OP_INSERT, 32'h0000_0000);
        send_item(lovt_pkg::OP_INSERT, 32'hAAAA_5555);
        send_item(lovt_pkg::OP_SEARCH, 32'hFFFF_FFFF);
        send_item(lovt_pkg::OP_SEARCH, 32'h0000_3039);
        send_item(lovt_pkg::OP_DELETE, 32'h7FFF_FFFF);
        // delete takes the later duplicate; the earlier one stays findable
        send_item(lovt_pkg::OP_DELETE, 32'h8000_0000);
        send_item(lovt_pkg::OP_SEARCH, 32'h8000_0000);
        send_item(OP_UNUSED, 32'h0000_0000);
        // delete a mid-table entry, then the remaining copy of the duplicate, then a delete that misses
        send_item(lovt_pkg::OP_DELETE, 32'hAAAA_5555);
        send_item(lovt_pkg::OP_DELETE, 32'h8000_0000);
        send_item(lovt_pkg::OP_DELETE, 32'h8000_0000);

        run_traffic(470);

        send_idle_pct = 63;
        recv_idle_pct = 21;
        run_traffic(470);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_traffic(460);

        s_tvalid <= 1'b0;
        while (table_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (table_sb.mismatches == 0 && table_sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
